FILE: sv/mre_pkg.sv
`default_nettype none

package mre_pkg;

	// fixed field widths
	localparam int CNT_W      = 6;            // row / column counts
	localparam int TOT_W      = 2 * CNT_W;    // element counts and linear positions
	localparam int MODE_W     = 2;
	localparam int FUNC_W     = 2;
	localparam int REG_IDX_W  = 2;
	localparam int DATA_W     = 64;
	localparam int DIV_CNT_W  = $clog2(TOT_W + 1);

	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_RESTART = 2'd2
	} func_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ROWS = 2'd0,
		MODE_COLS = 2'd1,
		MODE_CCW  = 2'd2
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_MODE = 2'd2
	} reg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic take;        // input beat accepted
		logic s1_load;     // read beat enters the RAM read stage
		logic out_load;    // read stage moves to the output register
		logic div_start;   // load divider with emitted count
		logic div_step;    // one quotient bit
		logic div_done;    // write quotient / remainder back to counters
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic item_read;   // current input beat yields a result
	} sts_t;

endpackage

`default_nettype wire

FILE: sv/mre_ram.sv
`default_nettype none

module mre_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/mre_ctrl.sv
`default_nettype none

module mre_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output      logic         in_ready,
	output      logic         out_valid,
	input  wire logic         out_ready,
	input  wire logic         cfg_valid,
	input  wire mre_pkg::sts_t sts,
	output      mre_pkg::cmd_t cmd
);

	typedef enum logic {
		ST_RUN,
		ST_DIV
	} state_t;

	state_t                          state_q;
	logic [mre_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic                            s1_v_q;
	logic                            out_v_q;
	logic                            s1_move;
	logic                            accept;
	logic                            div_last;

	assign div_last  = (div_cnt_q == mre_pkg::DIV_CNT_W'(mre_pkg::TOT_W));
	assign s1_move   = s1_v_q && (!out_v_q || out_ready);
	assign in_ready  = (state_q == ST_RUN) && (!s1_v_q || s1_move);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_v_q;

	always_comb begin
		cmd           = '0;
		cmd.take      = accept;
		cmd.s1_load   = accept && sts.item_read;
		cmd.out_load  = s1_move;
		cmd.div_start = cfg_valid;
		cmd.div_step  = (state_q == ST_DIV) && !div_last && !cfg_valid;
		cmd.div_done  = (state_q == ST_DIV) && div_last && !cfg_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			div_cnt_q <= '0;
			s1_v_q    <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			// a register write invalidates the row/column counters
			if (cfg_valid) begin
				state_q   <= ST_DIV;
				div_cnt_q <= '0;
			end else begin
				case (state_q)
					ST_DIV: begin
						if (div_last) begin
							state_q <= ST_RUN;
						end else begin
							div_cnt_q <= div_cnt_q + mre_pkg::DIV_CNT_W'(1);
						end
					end
					default: ;
				endcase
			end

			if (accept && sts.item_read) begin
				s1_v_q <= 1'b1;
			end else if (s1_move) begin
				s1_v_q <= 1'b0;
			end

			if (s1_move) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/mre_dpath.sv
`default_nettype none

module mre_dpath #(
	parameter int MAX_ROWS = mre_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mre_pkg::MAX_COLS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mre_pkg::cmd_t                     cmd,
	output      mre_pkg::sts_t                     sts,
	input  wire logic                              cfg_valid,
	input  wire logic [mre_pkg::REG_IDX_W-1:0]     cfg_index,
	input  wire logic [mre_pkg::CNT_W-1:0]         cfg_data,
	input  wire logic [mre_pkg::FUNC_W-1:0]        func,
	input  wire logic signed [mre_pkg::DATA_W-1:0] element_value,
	output      logic signed [mre_pkg::DATA_W-1:0] out_value,
	output      logic                              is_last,
	output      logic                              has_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = mre_pkg::CNT_W;
	localparam int TW    = mre_pkg::TOT_W;

	// configuration registers
	logic [CW-1:0]                  row_count_q;
	logic [CW-1:0]                  col_count_q;
	logic [mre_pkg::MODE_W-1:0]     order_mode_q;
	logic [CW-1:0]                  row_eff;
	logic [CW-1:0]                  col_eff;
	logic [TW-1:0]                  total_q;

	// sequencing counters
	logic [TW-1:0]                  load_pos_q;
	logic [TW-1:0]                  emit_q;
	logic [CW-1:0]                  inner_q;     // emitted mod rows
	logic [CW-1:0]                  outer_q;     // emitted div rows

	// restoring divider
	logic [CW-1:0]                  div_rem_q;
	logic [TW-1:0]                  div_quo_q;
	logic [CW:0]                    div_trial;
	logic                           div_ge;

	// read address path
	logic                           in_range;
	logic [TW:0]                    rot_sum;
	logic [TW-1:0]                  rot_src;
	logic [TW-1:0]                  col_prod;
	logic [CW-1:0]                  col_sel;
	logic [TW-1:0]                  col_src;
	logic [TW-1:0]                  rd_src;
	logic                           rd_ok;
	logic                           rd_last;
	logic                           load_ok;
	logic                           is_load;
	logic                           is_read;

	// RAM and output stages
	logic                           ram_we;
	logic                           ram_re;
	logic [mre_pkg::DATA_W-1:0]     ram_rdata;
	logic                           hd_s1;
	logic                           last_s1;
	logic signed [mre_pkg::DATA_W-1:0] out_value_q;
	logic                           is_last_q;
	logic                           has_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= CW'(1);
			col_count_q  <= CW'(1);
			order_mode_q <= mre_pkg::MODE_ROWS;
		end else if (cfg_valid) begin
			case (cfg_index)
				mre_pkg::REG_ROWS: row_count_q  <= cfg_data;
				mre_pkg::REG_COLS: col_count_q  <= cfg_data;
				mre_pkg::REG_MODE: order_mode_q <= cfg_data[mre_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign row_eff = (32'(row_count_q) > MAX_ROWS) ? CW'(MAX_ROWS) : row_count_q;
	assign col_eff = (32'(col_count_q) > MAX_COLS) ? CW'(MAX_COLS) : col_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TW'(1);
		end else begin
			total_q <= TW'(row_eff) * TW'(col_eff);
		end
	end

	assign is_load = (func == mre_pkg::FUNC_LOAD);
	assign is_read = (func == mre_pkg::FUNC_READ);
	assign sts.item_read = is_read;

	// mode 0: (k + cols) mod total, k < total so one subtract suffices
	assign in_range = (emit_q < total_q);
	assign rot_sum  = {1'b0, emit_q} + (TW + 1)'(col_eff);
	assign rot_src  = (rot_sum >= {1'b0, total_q}) ? TW'(rot_sum - {1'b0, total_q})
	                                                : TW'(rot_sum);

	// column orders: row index * cols + column
	assign col_prod = TW'(inner_q) * TW'(col_eff);
	assign col_src  = col_prod + TW'(col_sel);

	always_comb begin
		col_sel = outer_q;
		rd_src  = '0;
		rd_ok   = 1'b0;
		case (order_mode_q)
			mre_pkg::MODE_ROWS: begin
				rd_src = rot_src;
				rd_ok  = in_range && (row_eff >= CW'(2));
			end
			mre_pkg::MODE_COLS: begin
				rd_src = col_src;
				rd_ok  = in_range;
			end
			mre_pkg::MODE_CCW: begin
				col_sel = col_eff - CW'(1) - outer_q;
				rd_src  = col_src;
				rd_ok   = in_range;
			end
			default: ;
		endcase
	end

	assign rd_last = ((emit_q + TW'(1)) == total_q);
	assign load_ok = (load_pos_q < total_q);
	assign ram_we  = cmd.take && is_load && load_ok;
	assign ram_re  = cmd.take && is_read && rd_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			emit_q     <= '0;
			inner_q    <= '0;
			outer_q    <= '0;
		end else if (cmd.div_done) begin
			inner_q <= div_rem_q;
			outer_q <= div_quo_q[CW-1:0];
		end else if (cmd.take) begin
			case (func)
				mre_pkg::FUNC_LOAD: begin
					if (load_ok) begin
						load_pos_q <= load_pos_q + TW'(1);
					end
				end
				mre_pkg::FUNC_READ: begin
					if (rd_ok) begin
						emit_q <= emit_q + TW'(1);
						if ((inner_q + CW'(1)) == row_eff) begin
							inner_q <= '0;
							outer_q <= outer_q + CW'(1);
						end else begin
							inner_q <= inner_q + CW'(1);
						end
					end
				end
				mre_pkg::FUNC_RESTART: begin
					load_pos_q <= '0;
					emit_q     <= '0;
					inner_q    <= '0;
					outer_q    <= '0;
				end
				default: ;
			endcase
		end
	end

	// one quotient bit per step: emitted / rows
	assign div_trial = {div_rem_q, div_quo_q[TW-1]};
	assign div_ge    = (div_trial >= {1'b0, row_eff});

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= '0;
			div_quo_q <= emit_q;
		end else if (cmd.div_step) begin
			div_rem_q <= div_ge ? CW'(div_trial - {1'b0, row_eff}) : CW'(div_trial);
			div_quo_q <= {div_quo_q[TW-2:0], div_ge};
		end
	end

	mre_ram #(
		.WIDTH (mre_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(load_pos_q)),
		.wdata (element_value),
		.re    (ram_re),
		.raddr (AW'(rd_src)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.s1_load) begin
			hd_s1   <= rd_ok;
			last_s1 <= rd_ok && rd_last;
		end
		if (cmd.out_load) begin
			out_value_q <= hd_s1 ? ram_rdata : '0;
			is_last_q   <= last_s1;
			has_data_q  <= hd_s1;
		end
	end

	assign out_value = out_value_q;
	assign is_last   = is_last_q;
	assign has_data  = has_data_q;

endmodule

`default_nettype wire

FILE: sv/matrix_reorder_engine.sv
// Matrix reorder engine: load a row-major matrix, read it back reordered.
// Input channel (in_valid/in_ready): func selects load, read or restart;
// element_value is stored on a load beat. Every read beat gives exactly one
// output beat (out_valid/out_ready) with out_value, is_last and has_data;
// load and restart beats give none.
// Config channel (cfg_valid/cfg_ready): cfg_index picks row_count, col_count
// or order_mode; cfg_ready is always high. Write only while idle.
// Read path: a read result passes the RAM read stage, then the output register;
// it moves on only while the output register is free or out_ready is high.
// Throughput: one beat per cycle while results drain; each beat touches the
// store at most once. After each config write the input is held off while a
// bit-serial divider rebuilds the row/column counters (one bit per cycle).
// Stall: a RAM read stage and an output register hold up to two results;
// in_ready drops when both are full and out_ready is low, and while the divider runs.
// Reset: registers go to 1 row, 1 column, mode 0; all counters zero; the
// element store is not cleared, so no clearing pass is needed.
`default_nettype none

module matrix_reorder_engine #(
	parameter int MAX_ROWS = mre_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mre_pkg::MAX_COLS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input beats
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic [mre_pkg::FUNC_W-1:0]        func,
	input  wire logic signed [mre_pkg::DATA_W-1:0] element_value,
	// result beats
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic signed [mre_pkg::DATA_W-1:0] out_value,
	output      logic                              is_last,
	output      logic                              has_data,
	// register writes
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [mre_pkg::REG_IDX_W-1:0]     cfg_index,
	input  wire logic [mre_pkg::CNT_W-1:0]         cfg_data
);

	mre_pkg::cmd_t cmd;
	mre_pkg::sts_t sts;

	// registers always take a write beat at once
	assign cfg_ready = 1'b1;

	// handshakes, divider sequencing, stage occupancy
	mre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// registers, counters, address maths, element store, result payload
	mre_dpath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.element_value (element_value),
		.out_value     (out_value),
		.is_last       (is_last),
		.has_data      (has_data)
	);

`ifndef SYNTH
	// a register write must hold off input while the counters are rebuilt
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input accepted straight after a register write");

	// an empty result carries zero and never marks the end
	a_no_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_data |-> (out_value == '0) && !is_last)
		else $error("empty result with data or end mark");
`endif

endmodule

`default_nettype wire
